// ----- rtl/core/stb_pkg.sv -----
// Shared types and codes for the software timer bank.
// Holds command, status and result-kind codes and the slot record layout.
// No dependencies.
package stb_pkg;

  localparam int KEY_W    = 16;
  localparam int TICK_W   = 32;
  localparam int REPEAT_W = 31;

  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_REGISTER   = 3'd1;
  localparam logic [2:0] CMD_UNREGISTER = 3'd2;
  localparam logic [2:0] CMD_GET        = 3'd3;
  localparam logic [2:0] CMD_SET_REPEAT = 3'd4;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [REPEAT_W-1:0] REPEAT_MAX = {REPEAT_W{1'b1}};

  // One timer slot as held in the slot memory.
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [TICK_W-1:0]   elapsed;
    logic [TICK_W-1:0]   period;
    logic [REPEAT_W-1:0] repeat_cnt;
  } slot_t;

  // Result item as held in the output register.
  typedef struct packed {
    logic                kind;
    logic [1:0]          status;
    logic [KEY_W-1:0]    key;
    logic [TICK_W-1:0]   elapsed;
    logic [TICK_W-1:0]   period;
    logic [REPEAT_W-1:0] repeat_cnt;
    logic                found;
    logic                last;
  } result_t;

endpackage

// ----- rtl/core/software_timer_bank.sv -----
// Timer table: NUM_TIMERS slots in one synchronous memory, scanned one slot per cycle;
// a stalled output holds the scan in place. Fired items come out during the scan and the
// completion follows it. A new command is taken only in the idle state, once the last
// completion has been loaded into the output register; the slot memory has one read port.
// Reset: the sequencer goes idle and every slot is marked free; slot memory is not cleared.
// Depends on stb_pkg.
module software_timer_bank #(
  parameter int NUM_TIMERS = 32,
  parameter int KEY_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata, from bit 0: timer_key[15:0], period_ticks[31:0], repeat_value[30:0],
  // delta_ticks[31:0], one zero pad bit.
  input  logic [111:0] in_tdata,
  // in_tuser: command[2:0].
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata, from bit 0: status[1:0], out_key[15:0], elapsed_ticks[31:0],
  // out_period[31:0], repeat_count[30:0], found, six zero pad bits.
  output logic [119:0] out_tdata,
  // out_tuser: kind.
  output logic         out_tuser,
  output logic         out_tlast
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);
  localparam logic [15:0] KEY_MASK =
    (KEY_BITS >= 16) ? 16'hFFFF : 16'((17'd1 << KEY_BITS) - 17'd1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Latched command.
  logic [2:0]                     cmd_r;
  logic [stb_pkg::KEY_W-1:0]      key_r;
  logic [stb_pkg::TICK_W-1:0]     period_r;
  logic [stb_pkg::REPEAT_W-1:0]   rep_r;
  logic [stb_pkg::TICK_W-1:0]     delta_r;

  logic [IW-1:0]         idx_r;
  logic [NUM_TIMERS-1:0] active_r, active_nxt;
  // Set once the scan has found its slot: the hit for lookups, the free slot for register.
  logic                  flag_r, flag_nxt;
  logic [stb_pkg::TICK_W-1:0]   hit_el_r, hit_per_r;
  logic [stb_pkg::REPEAT_W-1:0] hit_rep_r;
  logic                         hit_load;

  // Slot memory.
  stb_pkg::slot_t mem [NUM_TIMERS];
  stb_pkg::slot_t rdata_r, wdata;
  logic           rd_en, we;
  logic [IW-1:0]  rd_addr;

  stb_pkg::result_t out_r, res;
  logic             out_valid_r, out_load, out_free;

  logic        accept, slot_act, key_hit, fire, advance;
  logic [32:0] sum;
  logic [stb_pkg::TICK_W-1:0] sum_sat;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign slot_act = active_r[idx_r];
  assign key_hit  = slot_act && (rdata_r.key == key_r);
  assign sum      = {1'b0, rdata_r.elapsed} + {1'b0, delta_r};
  assign sum_sat  = sum[32] ? {stb_pkg::TICK_W{1'b1}} : sum[31:0];
  assign fire     = slot_act && (sum_sat >= rdata_r.period);

  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    flag_nxt   = flag_r;
    hit_load   = 1'b0;
    we         = 1'b0;
    wdata      = rdata_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    out_load   = 1'b0;
    res        = '0;
    advance    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rd_en     = 1'b1;
          flag_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        advance = 1'b1;
        case (cmd_r)
          stb_pkg::CMD_TICK: begin
            if (slot_act) begin
              we            = 1'b1;
              wdata.elapsed = sum_sat;
              if (fire) begin
                advance        = out_free;
                out_load       = out_free;
                res.kind       = stb_pkg::KIND_FIRED;
                res.status     = stb_pkg::STATUS_OK;
                res.key        = rdata_r.key;
                res.elapsed    = sum_sat;
                res.period     = rdata_r.period;
                res.repeat_cnt = rdata_r.repeat_cnt;
                if (rdata_r.repeat_cnt != '0) begin
                  wdata.elapsed = sum_sat - rdata_r.period;
                  if (rdata_r.repeat_cnt != stb_pkg::REPEAT_MAX) begin
                    wdata.repeat_cnt = rdata_r.repeat_cnt + 1'b1;
                  end
                end else if (out_free) begin
                  active_nxt[idx_r] = 1'b0;
                end
              end
              we = advance;
            end
          end
          stb_pkg::CMD_REGISTER: begin
            // Slots with the same key are freed; the lowest free one takes the timer.
            if (!flag_r && (!slot_act || key_hit)) begin
              we                = 1'b1;
              wdata.key         = key_r;
              wdata.elapsed     = '0;
              wdata.period      = period_r;
              wdata.repeat_cnt  = rep_r;
              active_nxt[idx_r] = 1'b1;
              flag_nxt          = 1'b1;
            end else if (key_hit) begin
              active_nxt[idx_r] = 1'b0;
            end
          end
          stb_pkg::CMD_UNREGISTER: begin
            if (!flag_r && key_hit) begin
              active_nxt[idx_r] = 1'b0;
              flag_nxt          = 1'b1;
            end
          end
          stb_pkg::CMD_GET: begin
            if (!flag_r && key_hit) begin
              hit_load = 1'b1;
              flag_nxt = 1'b1;
            end
          end
          stb_pkg::CMD_SET_REPEAT: begin
            if (!flag_r && key_hit) begin
              we               = 1'b1;
              wdata.repeat_cnt = rep_r;
              flag_nxt         = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (advance) begin
          if (idx_r == LAST_IDX) begin
            state_nxt = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        res.kind = stb_pkg::KIND_STATUS;
        res.key  = key_r & KEY_MASK;
        res.last = 1'b1;
        case (cmd_r)
          stb_pkg::CMD_REGISTER:
            res.status = flag_r ? stb_pkg::STATUS_OK : stb_pkg::STATUS_FULL;
          stb_pkg::CMD_UNREGISTER, stb_pkg::CMD_SET_REPEAT:
            res.status = flag_r ? stb_pkg::STATUS_OK : stb_pkg::STATUS_NOT_FOUND;
          stb_pkg::CMD_GET: begin
            res.status = flag_r ? stb_pkg::STATUS_OK : stb_pkg::STATUS_NOT_FOUND;
            if (flag_r) begin
              res.elapsed    = hit_el_r;
              res.period     = hit_per_r;
              res.repeat_cnt = hit_rep_r;
              res.found      = 1'b1;
            end
          end
          default: res.status = stb_pkg::STATUS_OK;
        endcase
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx_r] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      flag_r   <= flag_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_tuser;
      key_r    <= in_tdata[15:0] & KEY_MASK;
      period_r <= in_tdata[47:16];
      rep_r    <= in_tdata[78:48];
      delta_r  <= in_tdata[110:79];
      idx_r    <= '0;
    end else if (state_r == S_SCAN && advance && idx_r != LAST_IDX) begin
      idx_r <= idx_r + 1'b1;
    end
    if (hit_load) begin
      hit_el_r  <= rdata_r.elapsed;
      hit_per_r <= rdata_r.period;
      hit_rep_r <= rdata_r.repeat_cnt;
    end
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {6'b0, out_r.found, out_r.repeat_cnt, out_r.period, out_r.elapsed,
                       out_r.key, out_r.status};

  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == stb_pkg::KIND_FIRED) |-> !out_tlast)
    else $error("fired item marked as last");

  a_found_only_on_completion: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[113] |-> out_tlast && (out_tuser == stb_pkg::KIND_STATUS))
    else $error("found set on a non-completion item");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> (state_r == S_SCAN) && (idx_r == '0))
    else $error("accepted command did not start a scan at slot zero");

  a_scan_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= LAST_IDX))
    else $error("scan index beyond the table");

endmodule

// ----- dv/timer_bank_checker.sv -----
`timescale 1ns / 100ps
// Checker for the software timer bank: watches both stream channels and keeps its own timer table.
// Predicts every result of each accepted command and compares it field by field; depends on stb_pkg.
module timer_bank_checker #(
  parameter int NUM_TIMERS = 32,
  parameter int KEY_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [119:0] out_tdata,
  input  logic         out_tuser,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending,
  output int           fired_count,
  output int           command_count
);

  localparam logic [63:0] KEY_MASK_FULL = (64'd1 << KEY_BITS) - 64'd1;
  localparam logic [stb_pkg::KEY_W-1:0] KEY_MASK = KEY_MASK_FULL[stb_pkg::KEY_W-1:0];

  logic                         tbl_active  [NUM_TIMERS];
  logic [stb_pkg::KEY_W-1:0]    tbl_key     [NUM_TIMERS];
  logic [stb_pkg::TICK_W-1:0]   tbl_elapsed [NUM_TIMERS];
  logic [stb_pkg::TICK_W-1:0]   tbl_period  [NUM_TIMERS];
  logic [stb_pkg::REPEAT_W-1:0] tbl_repeat  [NUM_TIMERS];

  stb_pkg::result_t expected_results[$];
  stb_pkg::result_t oldest;

  // Lowest active slot holding the key, or -1.
  function automatic int find_timer(logic [stb_pkg::KEY_W-1:0] key);
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (tbl_active[i] && tbl_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void push_completion(logic [1:0] status, logic [stb_pkg::KEY_W-1:0] key,
                                          logic [stb_pkg::TICK_W-1:0] el,
                                          logic [stb_pkg::TICK_W-1:0] per,
                                          logic [stb_pkg::REPEAT_W-1:0] rep, logic found);
    stb_pkg::result_t r;
    r.kind       = stb_pkg::KIND_STATUS;
    r.status     = status;
    r.key        = key;
    r.elapsed    = el;
    r.period     = per;
    r.repeat_cnt = rep;
    r.found      = found;
    r.last       = 1'b1;
    expected_results.push_back(r);
  endfunction

  task automatic predict_command(logic [2:0] cmd, logic [stb_pkg::KEY_W-1:0] key_in,
                                 logic [stb_pkg::TICK_W-1:0] period,
                                 logic [stb_pkg::REPEAT_W-1:0] rep,
                                 logic [stb_pkg::TICK_W-1:0] delta);
    logic [stb_pkg::KEY_W-1:0] key;
    logic [stb_pkg::TICK_W:0]  sum;
    stb_pkg::result_t          fired;
    int                        slot;
    key = key_in & KEY_MASK;
    case (cmd)
      stb_pkg::CMD_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (tbl_active[i]) begin
            sum = {1'b0, tbl_elapsed[i]} + {1'b0, delta};
            tbl_elapsed[i] = sum[stb_pkg::TICK_W] ? '1 : sum[stb_pkg::TICK_W-1:0];
            if (tbl_elapsed[i] >= tbl_period[i]) begin
              fired.kind       = stb_pkg::KIND_FIRED;
              fired.status     = stb_pkg::STATUS_OK;
              fired.key        = tbl_key[i];
              fired.elapsed    = tbl_elapsed[i];
              fired.period     = tbl_period[i];
              fired.repeat_cnt = tbl_repeat[i];
              fired.found      = 1'b0;
              fired.last       = 1'b0;
              expected_results.push_back(fired);
              if (tbl_repeat[i] != '0) begin
                tbl_elapsed[i] = tbl_elapsed[i] - tbl_period[i];
                if (tbl_repeat[i] != stb_pkg::REPEAT_MAX) tbl_repeat[i] = tbl_repeat[i] + 1'b1;
              end else begin
                tbl_active[i] = 1'b0;
              end
            end
          end
        end
        push_completion(stb_pkg::STATUS_OK, key, '0, '0, '0, 1'b0);
      end
      stb_pkg::CMD_REGISTER: begin
        // Any slot already holding the key is released before a free slot is chosen.
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (tbl_active[i] && tbl_key[i] == key) tbl_active[i] = 1'b0;
        end
        slot = -1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (!tbl_active[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
          push_completion(stb_pkg::STATUS_FULL, key, '0, '0, '0, 1'b0);
        end else begin
          tbl_active[slot]  = 1'b1;
          tbl_key[slot]     = key;
          tbl_elapsed[slot] = '0;
          tbl_period[slot]  = period;
          tbl_repeat[slot]  = rep;
          push_completion(stb_pkg::STATUS_OK, key, '0, '0, '0, 1'b0);
        end
      end
      stb_pkg::CMD_UNREGISTER: begin
        slot = find_timer(key);
        if (slot < 0) begin
          push_completion(stb_pkg::STATUS_NOT_FOUND, key, '0, '0, '0, 1'b0);
        end else begin
          tbl_active[slot] = 1'b0;
          push_completion(stb_pkg::STATUS_OK, key, '0, '0, '0, 1'b0);
        end
      end
      stb_pkg::CMD_GET: begin
        slot = find_timer(key);
        if (slot < 0) begin
          push_completion(stb_pkg::STATUS_NOT_FOUND, key, '0, '0, '0, 1'b0);
        end else begin
          push_completion(stb_pkg::STATUS_OK, key, tbl_elapsed[slot], tbl_period[slot],
                          tbl_repeat[slot], 1'b1);
        end
      end
      stb_pkg::CMD_SET_REPEAT: begin
        slot = find_timer(key);
        if (slot < 0) begin
          push_completion(stb_pkg::STATUS_NOT_FOUND, key, '0, '0, '0, 1'b0);
        end else begin
          tbl_repeat[slot] = rep;
          push_completion(stb_pkg::STATUS_OK, key, '0, '0, '0, 1'b0);
        end
      end
      default: begin
        push_completion(stb_pkg::STATUS_OK, key, '0, '0, '0, 1'b0);
      end
    endcase
  endtask

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) tbl_active[i] = 1'b0;
      expected_results.delete();
    end else begin
      // The command is predicted before the result side so a same-edge result finds its entry.
      if (in_tvalid && in_tready) begin
        predict_command(in_tuser, in_tdata[15:0], in_tdata[47:16], in_tdata[78:48],
                        in_tdata[110:79]);
        command_count++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: kind %0h key %0h",
                 out_tuser, out_tdata[17:2]);
          fail_count++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("kind", 32'(oldest.kind), 32'(out_tuser));
          check_field("status", 32'(oldest.status), 32'(out_tdata[1:0]));
          check_field("out_key", 32'(oldest.key), 32'(out_tdata[17:2]));
          check_field("elapsed_ticks", oldest.elapsed, out_tdata[49:18]);
          check_field("out_period", oldest.period, out_tdata[81:50]);
          check_field("repeat_count", 32'(oldest.repeat_cnt), 32'(out_tdata[112:82]));
          check_field("found", 32'(oldest.found), 32'(out_tdata[113]));
          check_field("last", 32'(oldest.last), 32'(out_tlast));
          if (oldest.kind == stb_pkg::KIND_FIRED) fired_count++;
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the software timer bank testbench: clock, reset, command stimulus and the verdict.
// Instantiates the block and timer_bank_checker side by side; depends on stb_pkg.
module tb_top;

  localparam int NUM_TIMERS     = 32;
  localparam int KEY_BITS       = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * (NUM_TIMERS + 2);
  localparam int PHASE_COMMANDS = 110;
  localparam int KEY_POOL_SIZE  = 24;

  // Command codes the block does not define; they must still complete.
  localparam logic [2:0] CMD_UNUSED_LO = stb_pkg::CMD_SET_REPEAT + 3'd1;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic [111:0] in_tdata   = '0;
  logic [2:0]   in_tuser   = '0;
  logic         out_tready = 1'b0;
  logic         in_tready;
  logic         out_tvalid;
  logic [119:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  int fail_count;
  int pending;
  int fired_count;
  int command_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles  = 0;

  logic [15:0] key_pool [KEY_POOL_SIZE];

  always #6 clk = ~clk;

  software_timer_bank #(
    .NUM_TIMERS(NUM_TIMERS),
    .KEY_BITS  (KEY_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  timer_bank_checker #(
    .NUM_TIMERS(NUM_TIMERS),
    .KEY_BITS  (KEY_BITS)
  ) timer_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .fired_count  (fired_count),
    .command_count(command_count)
  );

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Ends the run when neither channel completes a transfer for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_command(logic [2:0] cmd, logic [15:0] key, logic [31:0] period,
                              logic [30:0] rep, logic [31:0] delta);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, delta, rep, period, key};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Fills every slot, overflows the table, re-registers a held key and fires everything at once.
  task automatic fill_table();
    logic [15:0] base;
    bit          repeating [NUM_TIMERS + 1];
    base = 16'($urandom_range(0, 16'hFFFF - NUM_TIMERS));
    for (int i = 0; i <= NUM_TIMERS; i++) begin
      repeating[i] = ($urandom_range(0, 7) == 0);
      send_command(stb_pkg::CMD_REGISTER, base + 16'(i), $urandom_range(0, 3),
                   31'(repeating[i]), $urandom);
    end
    send_command(stb_pkg::CMD_REGISTER, base, $urandom_range(0, 3), 31'd0, $urandom);
    repeating[0] = 1'b0;
    send_command(stb_pkg::CMD_TICK, base, $urandom, 31'($urandom), 32'd3);
    for (int i = 0; i <= NUM_TIMERS; i++) begin
      if (repeating[i]) begin
        send_command(stb_pkg::CMD_UNREGISTER, base + 16'(i), $urandom, 31'($urandom),
                     $urandom);
      end
    end
  endtask

  task automatic random_command();
    logic [2:0]  cmd;
    logic [15:0] key;
    logic [31:0] period;
    logic [31:0] delta;
    logic [30:0] rep;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 30)      cmd = stb_pkg::CMD_TICK;
    else if (r < 55) cmd = stb_pkg::CMD_REGISTER;
    else if (r < 65) cmd = stb_pkg::CMD_UNREGISTER;
    else if (r < 80) cmd = stb_pkg::CMD_GET;
    else if (r < 92) cmd = stb_pkg::CMD_SET_REPEAT;
    else             cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    // Mostly a small set of keys so that lookups hit and the table fills up.
    key = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                       : key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    r = $urandom_range(0, 99);
    if (r < 50)      period = $urandom_range(0, 50);
    else if (r < 70) period = $urandom_range(0, 1000);
    else if (r < 85) period = $urandom;
    else if (r < 95) period = '0;
    else             period = '1;
    r = $urandom_range(0, 99);
    if (r < 50)      delta = $urandom_range(0, 20);
    else if (r < 75) delta = $urandom_range(0, 500);
    else if (r < 90) delta = $urandom;
    else if (r < 95) delta = '0;
    else             delta = '1;
    r = $urandom_range(0, 99);
    if (r < 35)      rep = '0;
    else if (r < 70) rep = 31'($urandom_range(1, 5));
    else if (r < 80) rep = stb_pkg::REPEAT_MAX - 31'($urandom_range(0, 15));
    else             rep = 31'($urandom);
    send_command(cmd, key, period, rep, delta);
  endtask

  initial begin
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = 16'($urandom);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 24;
    recv_idle_pct = 86;

    // Lookups on an empty table, then extreme keys, periods and repeat counts.
    send_command(stb_pkg::CMD_GET, 16'h0000, $urandom, 31'($urandom), $urandom);
    send_command(stb_pkg::CMD_UNREGISTER, 16'hFFFF, $urandom, 31'($urandom), $urandom);
    send_command(stb_pkg::CMD_SET_REPEAT, 16'h0005, $urandom, 31'd3, $urandom);
    send_command(stb_pkg::CMD_TICK, 16'h0000, $urandom, 31'($urandom), 32'd0);
    send_command(stb_pkg::CMD_REGISTER, 16'h0000, 32'd0, 31'd0, $urandom);
    send_command(stb_pkg::CMD_REGISTER, 16'hFFFF, '1, stb_pkg::REPEAT_MAX, $urandom);
    send_command(stb_pkg::CMD_REGISTER, 16'h1234, 32'd10, 31'd1, $urandom);
    // A second register of the same key replaces the first.
    send_command(stb_pkg::CMD_REGISTER, 16'h1234, 32'd20, 31'd0, $urandom);
    send_command(stb_pkg::CMD_REGISTER, 16'h00AA, '1, 31'd0, $urandom);
    send_command(stb_pkg::CMD_REGISTER, 16'h0BEE, 32'd1, stb_pkg::REPEAT_MAX - 31'd1,
                 $urandom);
    send_command(stb_pkg::CMD_GET, 16'h1234, $urandom, 31'($urandom), $urandom);
    // A zero period fires on a zero tick; two half-range ticks saturate the elapsed count.
    send_command(stb_pkg::CMD_TICK, 16'h4321, $urandom, 31'($urandom), 32'd0);
    send_command(stb_pkg::CMD_TICK, 16'h0001, $urandom, 31'($urandom), 32'h8000_0000);
    send_command(stb_pkg::CMD_TICK, 16'h0002, $urandom, 31'($urandom), 32'h8000_0000);
    send_command(stb_pkg::CMD_SET_REPEAT, 16'hFFFF, $urandom, 31'd0, $urandom);
    send_command(stb_pkg::CMD_GET, 16'hFFFF, $urandom, 31'($urandom), $urandom);
    send_command(stb_pkg::CMD_TICK, 16'hFFFF, $urandom, 31'($urandom), '1);
    send_command(stb_pkg::CMD_UNREGISTER, 16'h0BEE, $urandom, 31'($urandom), $urandom);
    send_command(CMD_UNUSED_LO, 16'($urandom), $urandom, 31'($urandom), $urandom);
    send_command(CMD_UNUSED_LO + 3'd1, 16'($urandom), $urandom, 31'($urandom), $urandom);
    send_command(CMD_UNUSED_HI, 16'($urandom), $urandom, 31'($urandom), $urandom);
    send_command(stb_pkg::CMD_GET, 16'h0BEE, $urandom, 31'($urandom), $urandom);
    send_command(stb_pkg::CMD_TICK, 16'h0000, $urandom, 31'($urandom), '1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < PHASE_COMMANDS; k++) begin
        if (k == PHASE_COMMANDS / 2) fill_table();
        random_command();
      end
      // Hold off the sender until the block has delivered everything.
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d commands (%0d fired timers) through directed cases, table overflow bursts",
             command_count, fired_count);
    $display("and random traffic under three pacing mixes of sender and receiver stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
